@@ hw/rtl/vlut_pkg.sv @@
// Shared constants, types and the gain table of the video lookup-table entry generator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package vlut_pkg;

    // Field and register widths
    localparam int LEVEL_W   = 8;
    localparam int LEVELS    = 1 << LEVEL_W;
    localparam int REG_IDX_W = 3;

    // Fixed-point gain constants (gains are scaled by 1000)
    localparam int GAIN_ONE   = 1000;
    localparam int GAIN_RANGE = 4;
    localparam int NEUTRAL    = 127;
    localparam int LUMA_PIVOT = 16;
    localparam int CHROMA_MID = 128;
    localparam int LEVEL_MAX  = 255;
    localparam int GAIN_W     = 12;   // largest gain is 4023

    // Datapath widths
    localparam int LQ_W    = 10;      // luma quotient, at most 961
    localparam int LPROD_W = 20;      // |index - 16| * gain
    localparam int GG_W    = 24;      // saturation gain * contrast gain
    localparam int CPROD_W = 31;      // |index - 128| * gain product
    localparam int CQ_W    = 12;      // chroma quotient, at most 2071

    // Reciprocals for the constant divisions, each an underestimate by less than one
    localparam int LUMA_RECIP_W   = 11;
    localparam int LUMA_SHIFT     = 20;
    localparam int LUMA_MUL_W     = LPROD_W + LUMA_RECIP_W;
    localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 11'd1048;
    localparam int CHROMA_RECIP_W = 21;
    localparam int CHROMA_SHIFT   = 40;
    localparam int CHROMA_MUL_W   = CPROD_W + CHROMA_RECIP_W;
    localparam logic [CHROMA_RECIP_W-1:0] CHROMA_RECIP = 21'd1099511;
    localparam logic [LPROD_W-1:0] LUMA_DIVISOR   = 20'd1000;
    localparam logic [CPROD_W-1:0] CHROMA_DIVISOR = 31'd1000000;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FIRST_BRIGHTNESS  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_CONTRAST    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_SATURATION  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_BRIGHTNESS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_CONTRAST   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_SATURATION = 3'd5;

    localparam logic [LEVEL_W-1:0] LEVEL_NEUTRAL = 8'd127;

    // One settings set
    typedef struct packed {
        logic [LEVEL_W-1:0] brightness;
        logic [LEVEL_W-1:0] contrast;
        logic [LEVEL_W-1:0] saturation;
    } settings_t;

    typedef logic [LEVELS-1:0][GAIN_W-1:0] gain_table_t;

    // Build the level-to-gain table at elaboration
    function automatic gain_table_t build_gain_table();
        gain_table_t t;
        int          g;
        for (int i = 0; i < LEVELS; i++) begin
            if (i > NEUTRAL) begin
                g = GAIN_ONE + ((i - NEUTRAL) * GAIN_ONE * (GAIN_RANGE - 1)) / NEUTRAL;
            end else begin
                g = (i * GAIN_ONE) / NEUTRAL;
            end
            t[i] = GAIN_W'(g);
        end
        return t;
    endfunction

    localparam gain_table_t GAIN_TABLE = build_gain_table();

endpackage

`default_nettype wire

@@ hw/rtl/vlut_pipe.sv @@
// Six-stage datapath of the video lookup-table entry generator.
// Depends on vlut_pkg for widths, reciprocals and the gain table.
`default_nettype none

module vlut_pipe
    import vlut_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [LEVEL_W-1:0] in_index,
    input  wire settings_t          in_settings,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [LEVEL_W-1:0]      out_number,
    output logic [LEVEL_W-1:0]      out_luma,
    output logic [LEVEL_W-1:0]      out_chroma
);

    localparam int NSTAGE = 6;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    // Stage enables: a stage loads when it is empty or its successor moves
    always_comb begin
        en[NSTAGE-1] = ~valid_reg[NSTAGE-1] | out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = ~valid_reg[k] | en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NSTAGE-1];

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: gain lookup and distances from the pivots
    logic [LEVEL_W-1:0] s1_idx_reg, s1_bri_reg, s1_lmag_reg, s1_cmag_reg;
    logic [GAIN_W-1:0]  s1_gc_reg, s1_gs_reg;
    logic               s1_lneg_reg, s1_cneg_reg;
    logic               s1_lneg_next, s1_cneg_next;
    logic [LEVEL_W-1:0] s1_lmag_next, s1_cmag_next;

    always_comb begin
        s1_lneg_next = in_index < LEVEL_W'(LUMA_PIVOT);
        s1_cneg_next = in_index < LEVEL_W'(CHROMA_MID);
        s1_lmag_next = s1_lneg_next ? LEVEL_W'(LUMA_PIVOT) - in_index
                                    : in_index - LEVEL_W'(LUMA_PIVOT);
        s1_cmag_next = s1_cneg_next ? LEVEL_W'(CHROMA_MID) - in_index
                                    : in_index - LEVEL_W'(CHROMA_MID);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_idx_reg  <= in_index;
            s1_bri_reg  <= in_settings.brightness;
            s1_gc_reg   <= GAIN_TABLE[in_settings.contrast];
            s1_gs_reg   <= GAIN_TABLE[in_settings.saturation];
            s1_lneg_reg <= s1_lneg_next;
            s1_cneg_reg <= s1_cneg_next;
            s1_lmag_reg <= s1_lmag_next;
            s1_cmag_reg <= s1_cmag_next;
        end
    end

    // Stage 2: luma product and combined chroma gain
    logic [LEVEL_W-1:0] s2_idx_reg, s2_bri_reg, s2_cmag_reg;
    logic               s2_lneg_reg, s2_cneg_reg;
    logic [LPROD_W-1:0] s2_lp_reg;
    logic [GG_W-1:0]    s2_gg_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_idx_reg  <= s1_idx_reg;
            s2_bri_reg  <= s1_bri_reg;
            s2_cmag_reg <= s1_cmag_reg;
            s2_lneg_reg <= s1_lneg_reg;
            s2_cneg_reg <= s1_cneg_reg;
            s2_lp_reg   <= LPROD_W'(s1_lmag_reg) * LPROD_W'(s1_gc_reg);
            s2_gg_reg   <= GG_W'(s1_gs_reg) * GG_W'(s1_gc_reg);
        end
    end

    // Stage 3: luma quotient estimate and chroma product
    logic [LEVEL_W-1:0]    s3_idx_reg, s3_bri_reg;
    logic                  s3_lneg_reg, s3_cneg_reg;
    logic [LPROD_W-1:0]    s3_lp_reg;
    logic [LQ_W-1:0]       s3_lqe_reg;
    logic [CPROD_W-1:0]    s3_cm_reg;
    logic [LUMA_MUL_W-1:0] s3_lmul_next;

    assign s3_lmul_next = LUMA_MUL_W'(s2_lp_reg) * LUMA_MUL_W'(LUMA_RECIP);

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s3_idx_reg  <= s2_idx_reg;
            s3_bri_reg  <= s2_bri_reg;
            s3_lneg_reg <= s2_lneg_reg;
            s3_cneg_reg <= s2_cneg_reg;
            s3_lp_reg   <= s2_lp_reg;
            s3_lqe_reg  <= s3_lmul_next[LUMA_SHIFT +: LQ_W];
            s3_cm_reg   <= CPROD_W'(s2_cmag_reg) * CPROD_W'(s2_gg_reg);
        end
    end

    // Stage 4: correct the luma quotient, estimate the chroma quotient
    logic [LEVEL_W-1:0]      s4_idx_reg, s4_bri_reg;
    logic                    s4_lneg_reg, s4_cneg_reg;
    logic [LQ_W-1:0]         s4_lq_reg;
    logic [CPROD_W-1:0]      s4_cm_reg;
    logic [CQ_W-1:0]         s4_cqe_reg;
    logic [LPROD_W-1:0]      s4_lrem_next;
    logic [LQ_W-1:0]         s4_lq_next;
    logic [CHROMA_MUL_W-1:0] s4_cmul_next;

    always_comb begin
        s4_lrem_next = s3_lp_reg - LPROD_W'(s3_lqe_reg) * LUMA_DIVISOR;
        s4_lq_next   = s3_lqe_reg + LQ_W'(s4_lrem_next >= LUMA_DIVISOR);
        s4_cmul_next = CHROMA_MUL_W'(s3_cm_reg) * CHROMA_MUL_W'(CHROMA_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s4_idx_reg  <= s3_idx_reg;
            s4_bri_reg  <= s3_bri_reg;
            s4_lneg_reg <= s3_lneg_reg;
            s4_cneg_reg <= s3_cneg_reg;
            s4_lq_reg   <= s4_lq_next;
            s4_cm_reg   <= s3_cm_reg;
            s4_cqe_reg  <= s4_cmul_next[CHROMA_SHIFT +: CQ_W];
        end
    end

    // Stage 5: finish luma with both clamps and the brightness offset; correct chroma
    logic [LEVEL_W-1:0] s5_idx_reg, s5_luma_reg;
    logic               s5_cneg_reg;
    logic [CQ_W-1:0]    s5_cq_reg;
    logic signed [11:0] s5_l0_next;
    logic [LEVEL_W-1:0] s5_l0c_next;
    logic signed [11:0] s5_off_next;
    logic signed [11:0] s5_sum_next;
    logic [LEVEL_W-1:0] s5_luma_next;
    logic [CPROD_W-1:0] s5_crem_next;
    logic [CQ_W-1:0]    s5_cq_next;

    always_comb begin
        s5_l0_next = s4_lneg_reg ? 12'(LUMA_PIVOT) - 12'(s4_lq_reg)
                                 : 12'(LUMA_PIVOT) + 12'(s4_lq_reg);
        if (s5_l0_next < 12'sd0) begin
            s5_l0c_next = '0;
        end else if (s5_l0_next > 12'(LEVEL_MAX)) begin
            s5_l0c_next = LEVEL_W'(LEVEL_MAX);
        end else begin
            s5_l0c_next = s5_l0_next[LEVEL_W-1:0];
        end
        // Offset is 2*(b-127), less one more below neutral
        if (s4_bri_reg >= LEVEL_NEUTRAL) begin
            s5_off_next = $signed({3'd0, s4_bri_reg, 1'b0}) - 12'sd254;
        end else begin
            s5_off_next = $signed({3'd0, s4_bri_reg, 1'b0}) - 12'sd255;
        end
        s5_sum_next = $signed({4'd0, s5_l0c_next}) + s5_off_next;
        if (s5_sum_next < 12'sd0) begin
            s5_luma_next = '0;
        end else if (s5_sum_next > 12'(LEVEL_MAX)) begin
            s5_luma_next = LEVEL_W'(LEVEL_MAX);
        end else begin
            s5_luma_next = s5_sum_next[LEVEL_W-1:0];
        end
        s5_crem_next = s4_cm_reg - CPROD_W'(s4_cqe_reg) * CHROMA_DIVISOR;
        s5_cq_next   = s4_cqe_reg + CQ_W'(s5_crem_next >= CHROMA_DIVISOR);
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s5_idx_reg  <= s4_idx_reg;
            s5_luma_reg <= s5_luma_next;
            s5_cneg_reg <= s4_cneg_reg;
            s5_cq_reg   <= s5_cq_next;
        end
    end

    // Stage 6: apply chroma sign around mid level and clamp
    logic [LEVEL_W-1:0] s6_idx_reg, s6_luma_reg, s6_chroma_reg;
    logic [LEVEL_W-1:0] s6_chroma_next;

    always_comb begin
        if (s5_cneg_reg) begin
            s6_chroma_next = (s5_cq_reg > CQ_W'(CHROMA_MID)) ? '0
                : LEVEL_W'(CQ_W'(CHROMA_MID) - s5_cq_reg);
        end else begin
            s6_chroma_next = (s5_cq_reg > CQ_W'(NEUTRAL)) ? LEVEL_W'(LEVEL_MAX)
                : LEVEL_W'(CQ_W'(CHROMA_MID) + s5_cq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            s6_idx_reg    <= s5_idx_reg;
            s6_luma_reg   <= s5_luma_reg;
            s6_chroma_reg <= s6_chroma_next;
        end
    end

    assign out_number = s6_idx_reg;
    assign out_luma   = s6_luma_reg;
    assign out_chroma = s6_chroma_reg;

endmodule

`default_nettype wire

@@ hw/rtl/video_lut_entry_generator.sv @@
// Video lookup-table entry generator: one luma and chroma entry per table index, from one
// of two brightness/contrast/saturation sets. It accepts one item per clock cycle unless
// backpressure from m_ready stalls it, and passes each item through a six-stage pipeline
// (gain lookup, two multiplier stages, two divide-by-constant stages with remainder
// correction, and a final clamp stage that is also the output register); backpressure
// stalls only the stages that are full. The user must write the registers through
// cfg_wr_en/cfg_index/cfg_data only while idle; the block itself does not enforce this.
// Depends on vlut_pkg and vlut_pipe.
`default_nettype none

module video_lut_entry_generator
    import vlut_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [LEVEL_W-1:0]   cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [LEVEL_W-1:0]   s_entry_index,
    input  wire logic                 s_use_second_set,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [LEVEL_W-1:0]        m_entry_number,
    output logic [LEVEL_W-1:0]        m_luma_value,
    output logic [LEVEL_W-1:0]        m_chroma_value
);

    settings_t first_reg, second_reg;
    settings_t sel_settings;

    // Write the settings registers; drop writes beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= '{LEVEL_NEUTRAL, LEVEL_NEUTRAL, LEVEL_NEUTRAL};
            second_reg <= '{LEVEL_NEUTRAL, LEVEL_NEUTRAL, LEVEL_NEUTRAL};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FIRST_BRIGHTNESS:  first_reg.brightness  <= cfg_data;
                REG_FIRST_CONTRAST:    first_reg.contrast    <= cfg_data;
                REG_FIRST_SATURATION:  first_reg.saturation  <= cfg_data;
                REG_SECOND_BRIGHTNESS: second_reg.brightness <= cfg_data;
                REG_SECOND_CONTRAST:   second_reg.contrast   <= cfg_data;
                REG_SECOND_SATURATION: second_reg.saturation <= cfg_data;
                default: ;
            endcase
        end
    end

    // Choose the settings set for the incoming item
    assign sel_settings = s_use_second_set ? second_reg : first_reg;

    vlut_pipe u_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_index    (s_entry_index),
        .in_settings (sel_settings),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_number  (m_entry_number),
        .out_luma    (m_luma_value),
        .out_chroma  (m_chroma_value)
    );

endmodule

`default_nettype wire
